[hw/rtl/life_grid_engine_defines.svh]
// assertion macros for the life grid engine
// LGE_ASSERT checks that a property holds, LGE_NEVER that a condition never holds
`ifndef LIFE_GRID_ENGINE_DEFINES_SVH
`define LIFE_GRID_ENGINE_DEFINES_SVH

`ifndef SYNTHESIS
`define LGE_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("life grid engine check failed");
`define LGE_NEVER(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("life grid engine forbidden condition");
`else
`define LGE_ASSERT(label, clk, rst_n, prop)
`define LGE_NEVER(label, clk, rst_n, cond)
`endif

`endif

[hw/rtl/lge_pkg.sv]
`timescale 1ns / 1ps

package lge_pkg;

    // grid size defaults
    localparam int ROWS_DEFAULT = 32;
    localparam int COLS_DEFAULT = 32;

    // fixed field widths
    localparam int CELL_ROW_W = 5;
    localparam int CELL_COL_W = 5;

    // life rule neighbor counts
    localparam logic [3:0] SURVIVE_CNT = 4'd2;
    localparam logic [3:0] BIRTH_CNT   = 4'd3;

    typedef enum logic [1:0] {
        OP_STEP   = 2'd0,
        OP_TOGGLE = 2'd1,
        OP_CLEAR  = 2'd2,
        OP_READ   = 2'd3
    } opcode_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_TGL_RD,
        S_TGL_WR,
        S_CLEAR,
        S_STEP,
        S_FETCH,
        S_EMIT
    } state_t;

    // controller to datapath commands
    typedef struct packed {
        logic latch;
        logic clear_all;
        logic rd_cell;
        logic tgl_wr;
        logic step_init;
        logic step_run;
        logic emit;
    } cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic step_done;
    } status_t;

endpackage

[hw/rtl/lge_ram.sv]
`timescale 1ns / 1ps

module lge_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[hw/rtl/lge_ctrl.sv]
`timescale 1ns / 1ps
`include "life_grid_engine_defines.svh"

module lge_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [1:0]       opcode,
    input  lge_pkg::status_t status,
    output lge_pkg::cmd_t    cmd,
    output logic             busy
);

    lge_pkg::state_t state_reg;
    lge_pkg::state_t state_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= lge_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            lge_pkg::S_IDLE:
            begin
                if (start)
                begin
                    cmd.latch = 1'b1;
                    case (lge_pkg::opcode_t'(opcode))
                        lge_pkg::OP_STEP:
                        begin
                            cmd.step_init = 1'b1;
                            state_next    = lge_pkg::S_STEP;
                        end
                        lge_pkg::OP_TOGGLE: state_next = lge_pkg::S_TGL_RD;
                        lge_pkg::OP_CLEAR:  state_next = lge_pkg::S_CLEAR;
                        lge_pkg::OP_READ:   state_next = lge_pkg::S_FETCH;
                        default:            state_next = lge_pkg::S_FETCH;
                    endcase
                end
            end
            lge_pkg::S_TGL_RD:
            begin
                cmd.rd_cell = 1'b1;
                state_next  = lge_pkg::S_TGL_WR;
            end
            lge_pkg::S_TGL_WR:
            begin
                cmd.tgl_wr = 1'b1;
                state_next = lge_pkg::S_FETCH;
            end
            lge_pkg::S_CLEAR:
            begin
                cmd.clear_all = 1'b1;
                state_next    = lge_pkg::S_FETCH;
            end
            lge_pkg::S_STEP:
            begin
                cmd.step_run = 1'b1;
                if (status.step_done)
                begin
                    state_next = lge_pkg::S_FETCH;
                end
            end
            lge_pkg::S_FETCH:
            begin
                cmd.rd_cell = 1'b1;
                state_next  = lge_pkg::S_EMIT;
            end
            lge_pkg::S_EMIT:
            begin
                cmd.emit   = 1'b1;
                state_next = lge_pkg::S_IDLE;
            end
            default:
            begin
                state_next = lge_pkg::S_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != lge_pkg::S_IDLE);

    // checks
    `LGE_ASSERT(a_accept_goes_busy, clk, rst_n, start && !busy |=> busy)
    `LGE_ASSERT(a_emit_then_idle, clk, rst_n, cmd.emit |=> !busy)
    `LGE_ASSERT(a_toggle_order, clk, rst_n, state_reg == lge_pkg::S_TGL_WR |-> $past(state_reg) == lge_pkg::S_TGL_RD)

endmodule

[hw/rtl/lge_datapath.sv]
`timescale 1ns / 1ps
`include "life_grid_engine_defines.svh"

module lge_datapath #(
    parameter int ROWS = lge_pkg::ROWS_DEFAULT,
    parameter int COLS = lge_pkg::COLS_DEFAULT
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic [lge_pkg::CELL_ROW_W-1:0]  cell_row,
    input  logic [lge_pkg::CELL_COL_W-1:0]  cell_col,
    input  lge_pkg::cmd_t                   cmd,
    output lge_pkg::status_t                status,
    output logic                            done,
    output logic                            cell_value
);

    localparam int RW  = $clog2(ROWS);
    localparam int CW  = $clog2(COLS);
    localparam int SCW = $clog2(ROWS + 3);
    localparam int REW = RW + lge_pkg::CELL_ROW_W;
    localparam int CEW = CW + lge_pkg::CELL_COL_W;

    // latched item
    logic [RW-1:0]  row_reg;
    logic [CW-1:0]  col_reg;
    logic           in_range_reg;
    logic [REW-1:0] row_ext;
    logic [CEW-1:0] col_ext;
    logic           in_range_next;

    // row window and step counter
    logic [COLS-1:0] prev_reg;
    logic [COLS-1:0] cur_reg;
    logic [COLS-1:0] nxt_reg;
    logic [SCW-1:0]  step_cnt_reg;
    logic [SCW-1:0]  step_wr_cnt;
    logic            step_rd;
    logic            step_load;
    logic            step_wr;

    // grid storage
    logic [ROWS-1:0] valid_reg;
    logic            rd_valid_reg;
    logic            rd_en;
    logic [RW-1:0]   rd_addr;
    logic [COLS-1:0] rd_data;
    logic [COLS-1:0] row_q;
    logic            tgl_en;
    logic            wr_en;
    logic [RW-1:0]   wr_addr;
    logic [COLS-1:0] wr_data;

    // next generation
    logic [COLS+1:0] pad_prev;
    logic [COLS+1:0] pad_cur;
    logic [COLS+1:0] pad_nxt;
    logic [COLS-1:0] gen_row;
    logic [3:0]      nbr_cnt;

    // result
    logic done_reg;
    logic cell_value_reg;
    logic cell_value_next;

    // address decode of the incoming item
    assign row_ext       = {{RW{1'b0}}, cell_row};
    assign col_ext       = {{CW{1'b0}}, cell_col};
    assign in_range_next = (32'(cell_row) < 32'(ROWS)) && (32'(cell_col) < 32'(COLS));

    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            row_reg      <= row_ext[RW-1:0];
            col_reg      <= col_ext[CW-1:0];
            in_range_reg <= in_range_next;
        end
    end

    // step sequencing: read row t, shift in row t-1, write new row t-3
    assign step_rd     = cmd.step_run && (step_cnt_reg < SCW'(ROWS));
    assign step_load   = cmd.step_run && (step_cnt_reg != '0) && (step_cnt_reg <= SCW'(ROWS));
    assign step_wr     = cmd.step_run && (step_cnt_reg >= SCW'(3));
    assign step_wr_cnt = step_cnt_reg - SCW'(3);
    assign status.step_done = (step_cnt_reg == SCW'(ROWS + 2));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_cnt_reg <= '0;
        end
        else if (cmd.step_init)
        begin
            step_cnt_reg <= '0;
        end
        else if (cmd.step_run)
        begin
            step_cnt_reg <= step_cnt_reg + SCW'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.step_init)
        begin
            prev_reg <= '0;
            cur_reg  <= '0;
            nxt_reg  <= '0;
        end
        else if (cmd.step_run)
        begin
            prev_reg <= cur_reg;
            cur_reg  <= nxt_reg;
            nxt_reg  <= step_load ? row_q : '0;
        end
    end

    // neighbor count and life rule per column, dead beyond the edges
    always_comb
    begin
        pad_prev = {1'b0, prev_reg, 1'b0};
        pad_cur  = {1'b0, cur_reg, 1'b0};
        pad_nxt  = {1'b0, nxt_reg, 1'b0};
        nbr_cnt  = '0;
        gen_row  = '0;
        for (int c = 0; c < COLS; c++)
        begin
            nbr_cnt = 4'(pad_prev[c]) + 4'(pad_prev[c+1]) + 4'(pad_prev[c+2])
                    + 4'(pad_cur[c]) + 4'(pad_cur[c+2])
                    + 4'(pad_nxt[c]) + 4'(pad_nxt[c+1]) + 4'(pad_nxt[c+2]);
            if (cur_reg[c])
            begin
                gen_row[c] = (nbr_cnt == lge_pkg::SURVIVE_CNT) ||
                             (nbr_cnt == lge_pkg::BIRTH_CNT);
            end
            else
            begin
                gen_row[c] = (nbr_cnt == lge_pkg::BIRTH_CNT);
            end
        end
    end

    // memory port muxing
    assign row_q   = rd_valid_reg ? rd_data : '0;
    assign tgl_en  = cmd.tgl_wr && in_range_reg;
    assign rd_en   = step_rd || (cmd.rd_cell && in_range_reg);
    assign rd_addr = step_rd ? step_cnt_reg[RW-1:0] : row_reg;
    assign wr_en   = step_wr || tgl_en;
    assign wr_addr = step_wr ? step_wr_cnt[RW-1:0] : row_reg;
    assign wr_data = step_wr ? gen_row : (row_q ^ (COLS'(1) << col_reg));

    lge_ram #(
        .WIDTH (COLS),
        .DEPTH (ROWS)
    ) u_grid_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // row valid bits, a row never written reads as dead
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.clear_all)
            begin
                valid_reg <= '0;
            end
            else if (wr_en)
            begin
                valid_reg[wr_addr] <= 1'b1;
            end
            if (rd_en)
            begin
                rd_valid_reg <= valid_reg[rd_addr];
            end
        end
    end

    // result register
    assign cell_value_next = in_range_reg ? row_q[col_reg] : 1'b0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg       <= 1'b0;
            cell_value_reg <= 1'b0;
        end
        else
        begin
            done_reg <= cmd.emit;
            if (cmd.emit)
            begin
                cell_value_reg <= cell_value_next;
            end
        end
    end

    assign done       = done_reg;
    assign cell_value = cell_value_reg;

    // checks
    `LGE_ASSERT(a_step_no_rw_clash, clk, rst_n, step_wr && rd_en |-> wr_addr != rd_addr)
    `LGE_NEVER(a_clear_no_write, clk, rst_n, cmd.clear_all && wr_en)

endmodule

[hw/rtl/life_grid_engine.sv]
`timescale 1ns / 1ps
`include "life_grid_engine_defines.svh"
// life grid engine: one item at a time, busy stays high until its result is out
// step: states STEP, FETCH, EMIT from accept to done (one row read and one row written per cycle)
// toggle: states TGL_RD, TGL_WR, FETCH, EMIT; clear: CLEAR, FETCH, EMIT; read: FETCH, EMIT before done
// the next item is taken in the cycle done is shown, the receiver cannot stall
// reset (rst_n, async, active low) clears all row valid bits, so the grid reads all dead

module life_grid_engine #(
    parameter int ROWS = lge_pkg::ROWS_DEFAULT,
    parameter int COLS = lge_pkg::COLS_DEFAULT
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic [1:0]                     opcode,
    input  logic [lge_pkg::CELL_ROW_W-1:0] cell_row,
    input  logic [lge_pkg::CELL_COL_W-1:0] cell_col,
    output logic                           done,
    output logic                           cell_value
);

    lge_pkg::cmd_t    cmd;
    lge_pkg::status_t status;

    // sequencing
    lge_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .opcode (opcode),
        .status (status),
        .cmd    (cmd),
        .busy   (busy)
    );

    // grid storage and life rule
    lge_datapath #(
        .ROWS (ROWS),
        .COLS (COLS)
    ) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cell_row   (cell_row),
        .cell_col   (cell_col),
        .cmd        (cmd),
        .status     (status),
        .done       (done),
        .cell_value (cell_value)
    );

    // checks
    `LGE_ASSERT(a_done_after_busy, clk, rst_n, done |-> $past(busy))

endmodule
